// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on rising edge and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AWRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("awrc assertion failed");

// Next-cycle implication.
`define AWRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("awrc assertion failed");

`endif

// ===== rtl/awrc_pkg.sv =====
package awrc_pkg;

   localparam int MAX_NODES   = 64;
   localparam int NODE_AW     = $clog2(MAX_NODES);
   localparam int MAX_DEGREE  = 8;
   localparam int DEG_AW      = $clog2(MAX_DEGREE);
   localparam int DEG_W       = DEG_AW + 1;
   localparam int EDGE_DEPTH  = MAX_NODES * MAX_DEGREE;
   localparam int QUEUE_DEPTH = 256;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QUEUE_AW + 1;

   localparam int CNT_W   = 7;
   localparam int TF_W    = 10;
   localparam int EW_W    = 8;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 10;
   localparam int COST_W  = 40;
   localparam int ACC_W   = 34;
   localparam int COORD_W = 16;
   localparam int WT_W    = 16;

   localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};
   localparam logic [ACC_W-1:0]  SQRT_BIT0 = ACC_W'(1) << 32;

   localparam logic [CSR_AW-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_TRAFFIC    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_ELEV_WT    = 2'd2;

   localparam logic [1:0] CMD_LOAD_NODE = 2'd0;
   localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
   localparam logic [1:0] CMD_SEARCH    = 2'd2;

   localparam logic [2:0] STAT_LOADED   = 3'd0;
   localparam logic [2:0] STAT_REJECTED = 3'd1;
   localparam logic [2:0] STAT_FOUND    = 3'd2;
   localparam logic [2:0] STAT_NO_PATH  = 3'd3;
   localparam logic [2:0] STAT_OVERFLOW = 3'd4;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] elev;
      logic                      traffic;
   } node_rec_type;

   typedef struct packed {
      logic [NODE_AW-1:0] tgt;
      logic [WT_W-1:0]    wt;
   } edge_rec_type;

   typedef struct packed {
      logic [COST_W-1:0]  key;
      logic [NODE_AW-1:0] node;
   } q_entry_type;

   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + (COST_W+1)'(b);
      return s[COST_W] ? COST_MAX : s[COST_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
   endfunction

endpackage

// ===== rtl/awrc_req_if.sv =====
interface awrc_req_if
   import awrc_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic [1:0]                command;
   logic [NODE_AW-1:0]        node_index;
   logic [NODE_AW-1:0]        target_index;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] elevation;
   logic                      traffic_flag;
   logic [WT_W-1:0]           edge_weight;
   logic [NODE_AW-1:0]        source_node;
   logic [NODE_AW-1:0]        dest_node;

   modport source (output valid, command, node_index, target_index, pos_x, pos_y,
                   elevation, traffic_flag, edge_weight, source_node, dest_node,
                   input ready);
   modport sink (input valid, command, node_index, target_index, pos_x, pos_y,
                 elevation, traffic_flag, edge_weight, source_node, dest_node,
                 output ready);
endinterface

// ===== rtl/awrc_rsp_if.sv =====
interface awrc_rsp_if
   import awrc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic [COST_W-1:0] path_cost;

   modport source (output valid, status, path_cost, input ready);
   modport sink (input valid, status, path_cost, output ready);
endinterface

// ===== rtl/awrc_ram.sv =====
module awrc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);
   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== rtl/astar_weighted_route_cost_top.sv =====
// channel   dir  handshake     payload
// req_chan  in   valid/ready   command, node/edge fields, search endpoints
// rsp_chan  out  valid/ready   status, path_cost
// csr       in   csr_wr_en     csr_index, csr_wdata
// Node load: written on acceptance. Edge load: degree read, then edge and degree write.
// Search: seed the queue, then per pop a scan of the queue RAM (one port), a fetch of
// the popped node and a cost check per edge; per relaxed edge a heuristic (two products
// on the one 16x16 multiplier, 17-step square root) and a push; then a final cost read.
// Synchronous reset; node, degree and cost stores use valid bits, no clearing pass.
// req ready only when idle and the response register is free or being taken.
module astar_weighted_route_cost_top
   import awrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   awrc_req_if.sink          req_chan,
   awrc_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_EDGE_WR, ST_RD_DST, ST_CAP_DST, ST_CAP_V, ST_H_MX, ST_H_MY,
      ST_H_SQ, ST_PUSH, ST_POP_START, ST_POP_RD, ST_POP_CMP, ST_POP_LAST,
      ST_POP_MOVE, ST_U_RD, ST_U_CAP, ST_E_CHK, ST_E_CAP, ST_E_NV, ST_E_MW,
      ST_E_ME, ST_E_CMP, ST_FIN_RD, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic [CNT_W-1:0] node_cnt_ff, node_cnt_in;
   logic [TF_W-1:0] tf_ff, tf_in;
   logic [EW_W-1:0] ew_ff, ew_in;
   logic [MAX_NODES-1:0] node_vld_ff, node_vld_in;
   logic [MAX_NODES-1:0] deg_vld_ff, deg_vld_in;
   logic [MAX_NODES-1:0] cost_vld_ff, cost_vld_in;
   logic [NODE_AW-1:0] node_rd_ff, deg_rd_ff, cost_rd_ff;
   logic [NODE_AW-1:0] ld_node_ff, ld_node_in, ld_tgt_ff, ld_tgt_in;
   logic [WT_W-1:0] ld_wt_ff, ld_wt_in;
   logic [NODE_AW-1:0] dst_ff, dst_in, u_ff, u_in, v_ff, v_in;
   logic [WT_W-1:0] w_ff, w_in;
   logic signed [COORD_W-1:0] xd_ff, xd_in, yd_ff, yd_in, eu_ff, eu_in;
   node_rec_type nv_ff, nv_in;
   logic [COST_W-1:0] bu_ff, bu_in, bv_ff, bv_in, nc_ff, nc_in;
   logic [DEG_W-1:0] deg_ff, deg_in, k_ff, k_in;
   logic [ACC_W-1:0] acc_ff, acc_in, root_ff, root_in, bit_ff, bit_in;
   logic [QCNT_W-1:0] qcnt_ff, qcnt_in, scan_ff, scan_in;
   logic [COST_W-1:0] best_key_ff, best_key_in;
   logic [NODE_AW-1:0] best_node_ff, best_node_in;
   logic [QUEUE_AW-1:0] best_idx_ff, best_idx_in;
   logic relax_ff, relax_in;

   logic node_we, deg_we, edge_we, cost_we, q_we;
   logic [NODE_AW-1:0] node_waddr, node_raddr, deg_waddr, deg_raddr;
   logic [NODE_AW-1:0] cost_waddr, cost_raddr;
   logic [NODE_AW+DEG_AW-1:0] edge_waddr, edge_raddr;
   logic [QUEUE_AW-1:0] q_waddr, q_raddr;
   node_rec_type node_wdata, node_rdata, node_q;
   logic [DEG_W-1:0] deg_wdata, deg_rdata, deg_q;
   edge_rec_type edge_wdata, edge_rdata;
   logic [COST_W-1:0] cost_wdata, cost_rdata, cost_q, nc;
   q_entry_type q_wdata, q_rdata;
   logic [COORD_W-1:0] mul_a, mul_b;
   logic [2*COORD_W-1:0] prod;
   logic [ACC_W-1:0] trial;
   logic [CNT_W-1:0] count_eff;
   logic accept;

   assign count_eff = (node_cnt_ff > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_cnt_ff;
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.path_cost = rsp_cost_ff;

   assign node_q = node_vld_ff[node_rd_ff] ? node_rdata : '0;
   assign deg_q = deg_vld_ff[deg_rd_ff] ? deg_rdata : '0;
   assign cost_q = cost_vld_ff[cost_rd_ff] ? cost_rdata : COST_MAX;
   assign prod = (2*COORD_W)'(mul_a) * (2*COORD_W)'(mul_b);
   assign trial = root_ff + bit_ff;
   assign nc = sat_add(bu_ff, acc_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_H_MX: begin
            mul_a = abs_diff(nv_ff.x, xd_ff);
            mul_b = abs_diff(nv_ff.x, xd_ff);
         end
         ST_H_MY: begin
            mul_a = abs_diff(nv_ff.y, yd_ff);
            mul_b = abs_diff(nv_ff.y, yd_ff);
         end
         ST_E_MW: begin
            mul_a = w_ff;
            mul_b = nv_ff.traffic ? COORD_W'(tf_ff) : COORD_W'(256);
         end
         ST_E_ME: begin
            mul_a = abs_diff(nv_ff.elev, eu_ff);
            mul_b = COORD_W'(ew_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_cost_in = rsp_cost_ff;
      node_cnt_in = node_cnt_ff;
      tf_in = tf_ff;
      ew_in = ew_ff;
      node_vld_in = node_vld_ff;
      deg_vld_in = deg_vld_ff;
      cost_vld_in = cost_vld_ff;
      ld_node_in = ld_node_ff;
      ld_tgt_in = ld_tgt_ff;
      ld_wt_in = ld_wt_ff;
      dst_in = dst_ff;
      u_in = u_ff;
      v_in = v_ff;
      w_in = w_ff;
      xd_in = xd_ff;
      yd_in = yd_ff;
      eu_in = eu_ff;
      nv_in = nv_ff;
      bu_in = bu_ff;
      bv_in = bv_ff;
      nc_in = nc_ff;
      deg_in = deg_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      qcnt_in = qcnt_ff;
      scan_in = scan_ff;
      best_key_in = best_key_ff;
      best_node_in = best_node_ff;
      best_idx_in = best_idx_ff;
      relax_in = relax_ff;

      node_we = 1'b0;
      node_waddr = req_chan.node_index;
      node_wdata = '{x: req_chan.pos_x, y: req_chan.pos_y, elev: req_chan.elevation,
                     traffic: req_chan.traffic_flag};
      node_raddr = v_ff;
      deg_we = 1'b0;
      deg_waddr = ld_node_ff;
      deg_wdata = deg_q + DEG_W'(1);
      deg_raddr = u_ff;
      edge_we = 1'b0;
      edge_waddr = {ld_node_ff, deg_q[DEG_AW-1:0]};
      edge_wdata = '{tgt: ld_tgt_ff, wt: ld_wt_ff};
      edge_raddr = {u_ff, k_ff[DEG_AW-1:0]};
      cost_we = 1'b0;
      cost_waddr = v_ff;
      cost_wdata = nc;
      cost_raddr = v_ff;
      q_we = 1'b0;
      q_waddr = qcnt_ff[QUEUE_AW-1:0];
      q_wdata = '{key: sat_add(nc_ff, root_ff), node: v_ff};
      q_raddr = scan_ff[QUEUE_AW-1:0];

      if (csr_wr_en) begin
         case (csr_index)
            CSR_NODE_COUNT: node_cnt_in = csr_wdata[CNT_W-1:0];
            CSR_TRAFFIC:    tf_in = csr_wdata[TF_W-1:0];
            CSR_ELEV_WT:    ew_in = csr_wdata[EW_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_cost_in = '0;
               case (req_chan.command)
                  CMD_LOAD_NODE: begin
                     node_we = 1'b1;
                     node_vld_in[req_chan.node_index] = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_status_in = STAT_LOADED;
                  end
                  CMD_LOAD_EDGE: begin
                     deg_raddr = req_chan.node_index;
                     ld_node_in = req_chan.node_index;
                     ld_tgt_in = req_chan.target_index;
                     ld_wt_in = req_chan.edge_weight;
                     state_in = ST_EDGE_WR;
                  end
                  CMD_SEARCH: begin
                     if ({1'b0, req_chan.source_node} >= count_eff ||
                         {1'b0, req_chan.dest_node} >= count_eff) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STAT_NO_PATH;
                     end else begin
                        cost_vld_in = '0;
                        dst_in = req_chan.dest_node;
                        v_in = req_chan.source_node;
                        nc_in = '0;
                        qcnt_in = '0;
                        relax_in = 1'b0;
                        state_in = ST_RD_DST;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = STAT_REJECTED;
                  end
               endcase
            end
         end
         ST_EDGE_WR: begin
            rsp_valid_in = 1'b1;
            if (deg_q < DEG_W'(MAX_DEGREE)) begin
               edge_we = 1'b1;
               deg_we = 1'b1;
               deg_vld_in[ld_node_ff] = 1'b1;
               rsp_status_in = STAT_LOADED;
            end else begin
               rsp_status_in = STAT_REJECTED;
            end
            state_in = ST_IDLE;
         end
         ST_RD_DST: begin
            node_raddr = dst_ff;
            state_in = ST_CAP_DST;
         end
         ST_CAP_DST: begin
            xd_in = node_q.x;
            yd_in = node_q.y;
            cost_we = 1'b1;
            cost_wdata = '0;
            cost_vld_in[v_ff] = 1'b1;
            state_in = ST_CAP_V;
         end
         ST_CAP_V: begin
            nv_in = node_q;
            state_in = ST_H_MX;
         end
         ST_H_MX: begin
            acc_in = ACC_W'(prod);
            state_in = ST_H_MY;
         end
         ST_H_MY: begin
            acc_in = acc_ff + ACC_W'(prod);
            root_in = '0;
            bit_in = SQRT_BIT0;
            state_in = ST_H_SQ;
         end
         ST_H_SQ: begin
            if (acc_ff >= trial) begin
               acc_in = acc_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == ACC_W'(1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (qcnt_ff == QCNT_W'(QUEUE_DEPTH)) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_OVERFLOW;
               rsp_cost_in = '0;
               state_in = ST_IDLE;
            end else begin
               q_we = 1'b1;
               qcnt_in = qcnt_ff + QCNT_W'(1);
               if (relax_ff) begin
                  k_in = k_ff + DEG_W'(1);
                  state_in = ST_E_CHK;
               end else begin
                  state_in = ST_POP_START;
               end
            end
         end
         ST_POP_START: begin
            scan_in = '0;
            state_in = (qcnt_ff == '0) ? ST_FIN_RD : ST_POP_RD;
         end
         ST_POP_RD: begin
            state_in = ST_POP_CMP;
         end
         ST_POP_CMP: begin
            if (scan_ff == '0 || q_rdata.key < best_key_ff ||
                (q_rdata.key == best_key_ff && q_rdata.node < best_node_ff)) begin
               best_key_in = q_rdata.key;
               best_node_in = q_rdata.node;
               best_idx_in = scan_ff[QUEUE_AW-1:0];
            end
            scan_in = scan_ff + QCNT_W'(1);
            state_in = (scan_ff + QCNT_W'(1) == qcnt_ff) ? ST_POP_LAST : ST_POP_RD;
         end
         ST_POP_LAST: begin
            q_raddr = QUEUE_AW'(qcnt_ff - QCNT_W'(1));
            state_in = ST_POP_MOVE;
         end
         ST_POP_MOVE: begin
            q_we = 1'b1;
            q_waddr = best_idx_ff;
            q_wdata = q_rdata;
            qcnt_in = qcnt_ff - QCNT_W'(1);
            u_in = best_node_ff;
            state_in = (best_node_ff == dst_ff) ? ST_FIN_RD : ST_U_RD;
         end
         ST_U_RD: begin
            deg_raddr = u_ff;
            cost_raddr = u_ff;
            node_raddr = u_ff;
            state_in = ST_U_CAP;
         end
         ST_U_CAP: begin
            deg_in = deg_q;
            bu_in = cost_q;
            eu_in = node_q.elev;
            k_in = '0;
            relax_in = 1'b1;
            state_in = ST_E_CHK;
         end
         ST_E_CHK: begin
            state_in = (k_ff == deg_ff) ? ST_POP_START : ST_E_CAP;
         end
         ST_E_CAP: begin
            v_in = edge_rdata.tgt;
            w_in = edge_rdata.wt;
            if ({1'b0, edge_rdata.tgt} >= count_eff) begin
               k_in = k_ff + DEG_W'(1);
               state_in = ST_E_CHK;
            end else begin
               node_raddr = edge_rdata.tgt;
               cost_raddr = edge_rdata.tgt;
               state_in = ST_E_NV;
            end
         end
         ST_E_NV: begin
            nv_in = node_q;
            bv_in = cost_q;
            state_in = ST_E_MW;
         end
         ST_E_MW: begin
            acc_in = ACC_W'(prod);
            state_in = ST_E_ME;
         end
         ST_E_ME: begin
            acc_in = acc_ff + ACC_W'(prod >> 4);
            state_in = ST_E_CMP;
         end
         ST_E_CMP: begin
            if (nc < bv_ff) begin
               cost_we = 1'b1;
               cost_vld_in[v_ff] = 1'b1;
               nc_in = nc;
               state_in = ST_H_MX;
            end else begin
               k_in = k_ff + DEG_W'(1);
               state_in = ST_E_CHK;
            end
         end
         ST_FIN_RD: begin
            cost_raddr = dst_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            if (cost_q == COST_MAX) begin
               rsp_status_in = STAT_NO_PATH;
               rsp_cost_in = '0;
            end else begin
               rsp_status_in = STAT_FOUND;
               rsp_cost_in = cost_q;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         node_cnt_ff <= CNT_W'(64);
         tf_ff <= TF_W'(384);
         ew_ff <= EW_W'(51);
         node_vld_ff <= '0;
         deg_vld_ff <= '0;
         cost_vld_ff <= '0;
         qcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         node_cnt_ff <= node_cnt_in;
         tf_ff <= tf_in;
         ew_ff <= ew_in;
         node_vld_ff <= node_vld_in;
         deg_vld_ff <= deg_vld_in;
         cost_vld_ff <= cost_vld_in;
         qcnt_ff <= qcnt_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_cost_ff <= rsp_cost_in;
      node_rd_ff <= node_raddr;
      deg_rd_ff <= deg_raddr;
      cost_rd_ff <= cost_raddr;
      ld_node_ff <= ld_node_in;
      ld_tgt_ff <= ld_tgt_in;
      ld_wt_ff <= ld_wt_in;
      dst_ff <= dst_in;
      u_ff <= u_in;
      v_ff <= v_in;
      w_ff <= w_in;
      xd_ff <= xd_in;
      yd_ff <= yd_in;
      eu_ff <= eu_in;
      nv_ff <= nv_in;
      bu_ff <= bu_in;
      bv_ff <= bv_in;
      nc_ff <= nc_in;
      deg_ff <= deg_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      scan_ff <= scan_in;
      best_key_ff <= best_key_in;
      best_node_ff <= best_node_in;
      best_idx_ff <= best_idx_in;
      relax_ff <= relax_in;
   end

   awrc_ram #(.DATA_W($bits(node_rec_type)), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
      .raddr(node_raddr), .rdata(node_rdata));

   awrc_ram #(.DATA_W(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
      .clock(clock), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
      .raddr(deg_raddr), .rdata(deg_rdata));

   awrc_ram #(.DATA_W($bits(edge_rec_type)), .DEPTH(EDGE_DEPTH)) u_edge_ram (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .raddr(edge_raddr), .rdata(edge_rdata));

   awrc_ram #(.DATA_W(COST_W), .DEPTH(MAX_NODES)) u_cost_ram (
      .clock(clock), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
      .raddr(cost_raddr), .rdata(cost_rdata));

   awrc_ram #(.DATA_W($bits(q_entry_type)), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata));

endmodule

// ===== rtl/awrc_chk.sv =====
`include "assert_macros.svh"

module awrc_chk
   import awrc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_command,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_status,
   input logic [COST_W-1:0] rsp_path_cost
);
   `AWRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `AWRC_ASSERT_SAME(a_no_accept_stalled, clock, reset, req_valid && req_ready, !rsp_valid || rsp_ready)
   `AWRC_ASSERT_NEXT(a_node_load_ack, clock, reset, req_valid && req_ready && req_command == CMD_LOAD_NODE, rsp_valid && rsp_status == STAT_LOADED)
   `AWRC_ASSERT_SAME(a_cost_zero, clock, reset, rsp_valid && rsp_status != STAT_FOUND, rsp_path_cost == '0)
endmodule

bind astar_weighted_route_cost_top awrc_chk u_awrc_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_command(req_chan.command),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status),
   .rsp_path_cost(rsp_chan.path_cost)
);

// ===== bench/tb_astar_weighted_route_cost_top.sv =====
`timescale 1ns / 1ps

module tb_astar_weighted_route_cost_top;
   import awrc_pkg::*;

   typedef struct {
      bit [1:0]         command;
      bit [5:0]         node_index;
      bit [5:0]         target_index;
      bit signed [15:0] pos_x;
      bit signed [15:0] pos_y;
      bit signed [15:0] elevation;
      bit               traffic_flag;
      bit [15:0]        edge_weight;
      bit [5:0]         source_node;
      bit [5:0]         dest_node;
   } route_item_type;

   typedef struct {
      bit [2:0]  status;
      bit [39:0] path_cost;
   } route_result_type;

   typedef struct {
      route_item_type   item;
      bit               typed;
      route_result_type res;
   } dir_row_type;

   localparam longint unsigned CMAX = 64'hFF_FFFF_FFFF;
   localparam bit [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   awrc_req_if req_bus();
   awrc_rsp_if rsp_bus();

   astar_weighted_route_cost_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   int unsigned cfg_count = 64, cfg_traffic = 384, cfg_elev_wt = 51;
   int node_x[64], node_y[64], node_elev[64];
   bit node_traffic[64];
   int unsigned degree[64];
   int unsigned edge_tgt[512], edge_wt[512];

   route_result_type pending_results[$];
   int errors = 0;
   bit no_gaps = 0;
   bit rsp_stalls = 1;
   int rsp_stall_left = 0;

   function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned root = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned heur(int a, int b);
      longint dx = longint'(node_x[a]) - node_x[b];
      longint dy = longint'(node_y[a]) - node_y[b];
      return isqrt(longint'(dx * dx) + longint'(dy * dy));
   endfunction

   function automatic longint unsigned sadd(longint unsigned a, longint unsigned b);
      longint unsigned s = a + b;
      return s > CMAX ? CMAX : s;
   endfunction

   function automatic route_result_type search_cost(int src, int dst);
      route_result_type r;
      int unsigned cnt;
      longint unsigned best[64];
      longint unsigned qkey[256];
      int qnode[256];
      int qcnt, u, v, bi, deg, slot;
      longint unsigned w, ad, nc;
      int d;
      r.status = STAT_NO_PATH;
      r.path_cost = 0;
      cnt = cfg_count > 64 ? 64 : cfg_count;
      if (src >= cnt || dst >= cnt) return r;
      foreach (best[i]) best[i] = CMAX;
      best[src] = 0;
      qkey[0] = heur(src, dst);
      qnode[0] = src;
      qcnt = 1;
      while (qcnt > 0) begin
         bi = 0;
         for (int i = 1; i < qcnt; i++)
            if (qkey[i] < qkey[bi] || (qkey[i] == qkey[bi] && qnode[i] < qnode[bi])) bi = i;
         u = qnode[bi];
         qcnt--;
         qkey[bi] = qkey[qcnt];
         qnode[bi] = qnode[qcnt];
         if (u == dst) break;
         deg = degree[u] > 8 ? 8 : degree[u];
         for (int k = 0; k < deg; k++) begin
            slot = u * 8 + k;
            v = edge_tgt[slot];
            if (v >= cnt) continue;
            w = node_traffic[v] ? longint'(edge_wt[slot]) * cfg_traffic
                                : longint'(edge_wt[slot]) << 8;
            d = node_elev[v] - node_elev[u];
            ad = d < 0 ? -d : d;
            nc = sadd(best[u], w + ((ad * cfg_elev_wt) >> 4));
            if (nc < best[v]) begin
               best[v] = nc;
               if (qcnt >= 256) begin
                  r.status = STAT_OVERFLOW;
                  return r;
               end
               qkey[qcnt] = sadd(nc, heur(v, dst));
               qnode[qcnt] = v;
               qcnt++;
            end
         end
      end
      if (best[dst] >= CMAX) return r;
      r.status = STAT_FOUND;
      r.path_cost = best[dst];
      return r;
   endfunction

   function automatic route_result_type predict_route(route_item_type it);
      route_result_type r;
      int slot;
      r.status = STAT_REJECTED;
      r.path_cost = 0;
      case (it.command)
         CMD_LOAD_NODE: begin
            node_x[it.node_index] = it.pos_x;
            node_y[it.node_index] = it.pos_y;
            node_elev[it.node_index] = it.elevation;
            node_traffic[it.node_index] = it.traffic_flag;
            r.status = STAT_LOADED;
         end
         CMD_LOAD_EDGE: begin
            if (degree[it.node_index] < 8) begin
               slot = it.node_index * 8 + degree[it.node_index];
               edge_tgt[slot] = it.target_index;
               edge_wt[slot] = it.edge_weight;
               degree[it.node_index]++;
               r.status = STAT_LOADED;
            end
         end
         CMD_SEARCH: r = search_cost(it.source_node, it.dest_node);
         default: ;
      endcase
      return r;
   endfunction

   function automatic int gap_len();
      if (no_gaps) return 0;
      return $urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : $urandom_range(3, 30);
   endfunction

   task automatic send_item(input route_item_type it, input bit typed,
                            input route_result_type tr);
      int gap;
      route_result_type r;
      gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= it.command;
      req_bus.node_index <= it.node_index;
      req_bus.target_index <= it.target_index;
      req_bus.pos_x <= it.pos_x;
      req_bus.pos_y <= it.pos_y;
      req_bus.elevation <= it.elevation;
      req_bus.traffic_flag <= it.traffic_flag;
      req_bus.edge_weight <= it.edge_weight;
      req_bus.source_node <= it.source_node;
      req_bus.dest_node <= it.dest_node;
      do @(posedge clock); while (!req_bus.ready);
      r = predict_route(it);
      pending_results.insert(pending_results.size(), typed ? tr : r);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input int unsigned val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DW'(val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_NODE_COUNT: cfg_count = val & 7'h7F;
         CSR_TRAFFIC:    cfg_traffic = val & 10'h3FF;
         default:        cfg_elev_wt = val & 8'hFF;
      endcase
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // response side
   always @(posedge clock) begin
      route_result_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected transfer status %0d cost %0d", $time,
                        rsp_bus.status, rsp_bus.path_cost);
               errors++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_bus.status !== e.status) begin
                  $display("%0t status expected %0d actual %0d", $time, e.status,
                           rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.path_cost !== e.path_cost) begin
                  $display("%0t path_cost expected %0d actual %0d", $time, e.path_cost,
                           rsp_bus.path_cost);
                  errors++;
               end
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
            rsp_stall_left = $urandom_range(0, 9) < 8 ? $urandom_range(0, 3)
                                                       : $urandom_range(4, 40);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #200000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      dir_row_type dir_tab[] = '{
         '{'{CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{STAT_FOUND, 0}},
         '{'{CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0, 5}, 1, '{STAT_NO_PATH, 0}},
         '{'{CMD_UNUSED, 63, 63, -1, -1, -1, 1, 16'hFFFF, 63, 63}, 1, '{STAT_REJECTED, 0}},
         '{'{CMD_LOAD_NODE, 0, 0, -32768, 32767, -32768, 0, 0, 0, 0}, 1,
           '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_NODE, 1, 0, 32767, -32768, 32767, 1, 0, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_NODE, 2, 0, 0, 0, 0, 1, 0, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_NODE, 3, 0, 256, 256, 16, 0, 0, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 0, 1, 0, 0, 0, 0, 65535, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 1, 2, 0, 0, 0, 0, 0, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 0, 2, 0, 0, 0, 0, 100, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 2, 3, 0, 0, 0, 0, 1, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 0, 63, 0, 0, 0, 0, 5, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0, 3}, 0, '{0, 0}},
         '{'{CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0, 0, 1}, 0, '{0, 0}},
         '{'{CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0, 3, 0}, 1, '{STAT_NO_PATH, 0}},
         '{'{CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0, 63, 63}, 1, '{STAT_FOUND, 0}},
         '{'{CMD_LOAD_EDGE, 2, 0, 0, 0, 0, 0, 7, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 2, 1, 0, 0, 0, 0, 7, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 2, 2, 0, 0, 0, 0, 3, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 2, 3, 0, 0, 0, 0, 0, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 2, 1, 0, 0, 0, 0, 9, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 2, 0, 0, 0, 0, 0, 1, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 2, 0, 0, 0, 0, 0, 2, 0, 0}, 1, '{STAT_LOADED, 0}},
         '{'{CMD_LOAD_EDGE, 2, 1, 0, 0, 0, 0, 4, 0, 0}, 1, '{STAT_REJECTED, 0}},
         '{'{CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0, 1, 3}, 0, '{0, 0}}
      };
      route_item_type it;
      route_result_type none;
      int sent, n, used, sel;
      int unsigned counts[] = '{1, 2, 64, 127, 80};

      none = '{0, 0};
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.node_index = '0;
      req_bus.target_index = '0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.elevation = '0;
      req_bus.traffic_flag = 1'b0;
      req_bus.edge_weight = '0;
      req_bus.source_node = '0;
      req_bus.dest_node = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
      drain();

      sent = 0;
      for (int ph = 0; sent < 550; ph++) begin
         if (ph < counts.size()) write_csr(CSR_NODE_COUNT, counts[ph]);
         else if ($urandom_range(0, 4) == 0) write_csr(CSR_NODE_COUNT, $urandom_range(1, 127));
         else write_csr(CSR_NODE_COUNT, $urandom_range(2, 12));
         case (ph % 4)
            0: write_csr(CSR_TRAFFIC, 0);
            1: write_csr(CSR_TRAFFIC, 1023);
            default: write_csr(CSR_TRAFFIC, $urandom_range(0, 1023));
         endcase
         case (ph % 3)
            0: write_csr(CSR_ELEV_WT, 255);
            1: write_csr(CSR_ELEV_WT, 0);
            default: write_csr(CSR_ELEV_WT, $urandom_range(0, 255));
         endcase
         no_gaps = (ph % 5 == 2);
         rsp_stalls = (ph % 5 != 3);
         used = cfg_count > 16 ? 16 : cfg_count;
         n = $urandom_range(30, 50);
         for (int k = 0; k < n; k++) begin
            it.node_index = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                      : $urandom_range(0, used - 1);
            it.target_index = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                        : $urandom_range(0, used - 1);
            it.pos_x = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 4095) - 2048;
            it.pos_y = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 4095) - 2048;
            it.elevation = $urandom();
            it.traffic_flag = $urandom_range(0, 1);
            it.edge_weight = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 50);
            it.source_node = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
                                                       : $urandom_range(0, used - 1);
            it.dest_node = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
                                                     : $urandom_range(0, used - 1);
            sel = $urandom_range(0, 19);
            if (sel < 7) it.command = CMD_LOAD_NODE;
            else if (sel < 13) it.command = CMD_LOAD_EDGE;
            else if (sel < 19) it.command = CMD_SEARCH;
            else it.command = CMD_UNUSED;
            send_item(it, 0, none);
            sent++;
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
